/* src/sfm_pkg.sv */
// Package for the substring first-match block: sizes, item and register types,
// and the case-folding helper. Used by every module under src; depends on nothing.
`default_nettype none

package sfm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 65536;

    localparam int LEN_W     = 5;                          // pattern_length register width
    localparam int WIN_IDX_W = $clog2(MAX_PATTERN);        // index into the window
    localparam int CNT_W     = $clog2(MAX_TEXT + 1);       // byte count, holds MAX_TEXT
    localparam int IDX_W     = 16;                         // match_index width
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2,
        REG_FOLD_CASE      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic             result_last;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      pattern_low_bytes;
        logic [63:0]      pattern_high_bytes;
        logic             fold_case;
    } t_cfg;

    // Maps ASCII upper-case letters to lower case when folding is on.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/sfm_cfg_regs.sv */
// APB-style register file for the substring first-match block.
// Holds pattern length, pattern bytes and the fold-case mode; uses sfm_pkg.
`default_nettype none

module sfm_cfg_regs
    import sfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [LEN_W-1:0] r_pattern_length;
    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic             r_fold_case;
    logic             w_write;
    t_reg_idx         w_reg;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_reg   = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_W'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_fold_case      <= 1'b0;
        end else if (w_write) begin
            case (w_reg)
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= pwdata[63:0];
                REG_PATTERN_HIGH:   r_pattern_high   <= pwdata[63:0];
                REG_FOLD_CASE:      r_fold_case      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_PATTERN_LENGTH: prdata = DATA_W'(r_pattern_length);
            REG_PATTERN_LOW:    prdata = DATA_W'(r_pattern_low);
            REG_PATTERN_HIGH:   prdata = DATA_W'(r_pattern_high);
            REG_FOLD_CASE:      prdata = DATA_W'(r_fold_case);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pattern_length     = r_pattern_length;
    assign o_cfg.pattern_low_bytes  = r_pattern_low;
    assign o_cfg.pattern_high_bytes = r_pattern_high;
    assign o_cfg.fold_case          = r_fold_case;

endmodule

`default_nettype wire

/* src/sfm_match_core.sv */
// Window shift, pattern compare and run state of the substring first-match block.
// Processes one item per step and presents the run result combinationally; uses sfm_pkg.
`default_nettype none

module sfm_match_core
    import sfm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  t_in_item      i_item,
    input  t_cfg          i_cfg,
    output t_out_item     o_result
);

    logic [7:0]       r_window [MAX_PATTERN];
    logic [7:0]       n_window [MAX_PATTERN];
    logic [CNT_W-1:0] r_bytes_seen;
    logic [CNT_W-1:0] n_bytes_seen;
    logic             r_match_seen;
    logic             n_match_seen;
    logic [IDX_W-1:0] r_first_index;
    logic [IDX_W-1:0] n_first_index;

    logic [7:0]       w_pattern [MAX_PATTERN];
    logic [LEN_W-1:0] w_len;
    logic             w_in_range;
    logic             w_equal;
    logic             w_hit;
    logic [CNT_W-1:0] w_count_inc;
    logic [CNT_W-1:0] w_start;

    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (p < 8) begin
                w_pattern[p] = i_cfg.pattern_low_bytes[8*(p%8) +: 8];
            end else begin
                w_pattern[p] = i_cfg.pattern_high_bytes[8*(p%8) +: 8];
            end
        end
    end

    assign w_len = (i_cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
                   LEN_W'(MAX_PATTERN) : i_cfg.pattern_length;

    // Bytes past the text limit leave the window and the match state alone.
    assign w_in_range  = r_bytes_seen < CNT_W'(MAX_TEXT);
    assign w_count_inc = r_bytes_seen + CNT_W'(1);
    assign w_start     = w_count_inc - CNT_W'(w_len);

    always_comb begin
        n_window[0] = i_item.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // Pattern byte i lines up with the window byte len-1-i places back.
    always_comb begin
        logic [LEN_W-1:0] idx;
        w_equal = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            idx = w_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < w_len) begin
                if (fold_byte(n_window[idx[WIN_IDX_W-1:0]], i_cfg.fold_case) !=
                    fold_byte(w_pattern[i], i_cfg.fold_case)) begin
                    w_equal = 1'b0;
                end
            end
        end
    end

    assign w_hit = w_in_range && !r_match_seen && (w_len != '0) &&
                   (w_count_inc >= CNT_W'(w_len)) && w_equal;

    always_comb begin
        n_bytes_seen  = w_in_range ? w_count_inc : r_bytes_seen;
        n_match_seen  = r_match_seen || w_hit;
        n_first_index = w_hit ? w_start[IDX_W-1:0] : r_first_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen  <= '0;
            r_match_seen  <= 1'b0;
            r_first_index <= '0;
        end else if (i_step) begin
            if (i_item.last_byte) begin
                r_bytes_seen  <= '0;
                r_match_seen  <= 1'b0;
                r_first_index <= '0;
            end else begin
                r_bytes_seen  <= n_bytes_seen;
                r_match_seen  <= n_match_seen;
                r_first_index <= n_first_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_in_range) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

    assign o_result.found       = n_match_seen;
    assign o_result.match_index = n_match_seen ? n_first_index : '0;
    assign o_result.result_last = 1'b1;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_bytes_seen == '0 && !r_match_seen)
        else $error("run state not cleared after the last item");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_seen <= CNT_W'(MAX_TEXT))
        else $error("byte count beyond text limit");

    a_match_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_seen |-> r_bytes_seen != '0)
        else $error("match recorded with no bytes seen");

endmodule

`default_nettype wire

/* src/substring_first_match.sv */
// Top level of the streaming substring first-match search.
// Instantiates sfm_cfg_regs and sfm_match_core; uses sfm_pkg.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------
//  in       | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out      | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  cfg      | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One text byte per cycle while no last byte is stalled: an item is held in the
// input register, then shifted into the window and compared with the pattern
// on its way out. A result is loaded into the output register when the last
// byte leaves the input register, and can be taken from there.
// Bytes that are not last keep flowing while a result waits; only a last byte
// waits for the output register to free up. Reset is synchronous; it clears the
// run state and the valid flags and resets the configuration registers.
`default_nettype none

module substring_first_match
    import sfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_advance;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    sfm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sfm_match_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // A last byte can only move on when the output register is free or draining.
    assign w_advance  = r_in_valid &&
                        (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_index_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.match_index == '0)
        else $error("nonzero index on a not-found result");

    a_result_last_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.result_last)
        else $error("result without its end mark");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("waiting item lost from the input register");

endmodule

`default_nettype wire
